[hdl/kri_pkg.sv]
package kri_pkg;

  localparam int MAX_KEYFRAMES = 64;
  localparam int MAX_AGENTS    = 16;

  localparam int FRAME_W = $clog2(MAX_KEYFRAMES);
  localparam int FC_W    = $clog2(MAX_KEYFRAMES + 1);
  localparam int SLOT_W  = $clog2(MAX_AGENTS);
  localparam int CNT_W   = $clog2(MAX_AGENTS + 1);
  localparam int AADDR_W = FRAME_W + SLOT_W;

  localparam int TIME_W     = 24;
  localparam int POS_W      = 24;
  localparam int ID_W       = 16;
  localparam int COLOR_W    = 32;
  localparam int SPEED_W    = 16;
  localparam int DELTA_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int OP_W       = 3;
  localparam int FACT_W     = 16;
  localparam int DVD_W      = 40;
  localparam int DVS_W      = 32;
  localparam int DCNT_W     = $clog2(DVD_W);
  localparam int NCOORD     = 3;
  localparam int COORD_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_TICK  = 3'd1,
    OP_SEEK  = 3'd2,
    OP_PLAY  = 3'd3,
    OP_PAUSE = 3'd4,
    OP_STOP  = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK_MUL, S_TICK_SUM, S_TICK_FIN, S_DIV_M, S_WALK_INIT, S_WALK_RD,
    S_WALK_CHK, S_SETUP, S_DECIDE, S_DIV_F, S_AG_RD, S_AG_TAKE, S_SC_RD, S_SC_CHK,
    S_LERP_MUL, S_LERP_ADD, S_OUT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [TIME_W-1:0]         key_time;
    logic                      new_keyframe;
    logic [ID_W-1:0]           agent_id;
    logic [NCOORD-1:0][POS_W-1:0] pos;     // [0]=x [1]=y [2]=z
    logic [COLOR_W-1:0]        color_rgba;
    logic [DELTA_W-1:0]        delta_time;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]           agent_id;
    logic [NCOORD-1:0][POS_W-1:0] pos;
    logic [COLOR_W-1:0]        color;
    logic [TIME_W-1:0]         play_time;
    logic                      is_playing;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [NCOORD-1:0][POS_W-1:0] pos;
    logic [COLOR_W-1:0]        color;
  } agent_rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [CNT_W-1:0]  cnt;
  } frame_rec_t;

  typedef struct packed {
    logic take;
    logic load;
    logic play;
    logic pause;
    logic seek;
    logic stop;
    logic tick_mul;
    logic tick_sum;
    logic tick_fin;
    logic tick_mod;
    logic div_start;
    logic div_sel_f;
    logic walk_init;
    logic frame_rd;
    logic walk_chk;
    logic setup;
    logic f_take;
    logic ag_rd;
    logic ag_take;
    logic sc_rd;
    logic sc_chk;
    logic lerp_mul;
    logic lerp_add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic playing;
    logic tick_div;
    logic div_done;
    logic walk_end;
    logic n_zero;
    logic mix;
    logic scan_any;
    logic id_match;
    logic scan_end;
    logic coord_last;
    logic out_free;
    logic last_agent;
  } sts_t;

endpackage

[hdl/kri_if.sv]
interface kri_in_if import kri_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [TIME_W-1:0]        key_time;
  logic                     new_keyframe;
  logic [ID_W-1:0]          agent_id;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [COLOR_W-1:0]       color_rgba;
  logic [DELTA_W-1:0]       delta_time;

  modport source (output valid, operation, key_time, new_keyframe, agent_id, pos_x, pos_y,
                  pos_z, color_rgba, delta_time, input ready);
  modport sink (input valid, operation, key_time, new_keyframe, agent_id, pos_x, pos_y,
                pos_z, color_rgba, delta_time, output ready);
endinterface

interface kri_out_if import kri_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          out_agent_id;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic signed [POS_W-1:0]  out_z;
  logic [COLOR_W-1:0]       out_color;
  logic [TIME_W-1:0]        play_time;
  logic                     is_playing;
  logic                     last;

  modport source (output valid, out_agent_id, out_x, out_y, out_z, out_color, play_time,
                  is_playing, last, input ready);
  modport sink (input valid, out_agent_id, out_x, out_y, out_z, out_color, play_time,
                is_playing, last, output ready);
endinterface

[hdl/keyframe_replay_interpolator.sv]
// channel   | ports     | carries
// ----------+-----------+--------------------------------------------------
// request   | in_req    | load / tick / seek / play / pause / stop
// result    | out_res   | one interpolated agent per transfer, last flagged
// config    | cfg_*     | speed, looping, duration writes
//
// Load, play, pause and dropped ticks complete in the idle state. A query walks keyframe
// times, waits on the shared divider for the blend factor between two keyframes (ticks
// that wrap wait on it once more), then per agent reads its record, compares ids in the
// later keyframe and blends each coordinate.
// Reset is synchronous; stores are not cleared. One request at a time; a stalled
// result register holds the walk until out_res.ready.
module keyframe_replay_interpolator import kri_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kri_in_if.sink                in_req,
  kri_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  req_t req;
  res_t res;
  logic out_valid;

  always_comb begin
    req.operation    = in_req.operation;
    req.key_time     = in_req.key_time;
    req.new_keyframe = in_req.new_keyframe;
    req.agent_id     = in_req.agent_id;
    req.pos[0]       = in_req.pos_x;
    req.pos[1]       = in_req.pos_y;
    req.pos[2]       = in_req.pos_z;
    req.color_rgba   = in_req.color_rgba;
    req.delta_time   = in_req.delta_time;
  end

  kri_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_op    (in_req.operation),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kri_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_res.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_res.valid        = out_valid;
  assign out_res.out_agent_id = res.agent_id;
  assign out_res.out_x        = res.pos[0];
  assign out_res.out_y        = res.pos[1];
  assign out_res.out_z        = res.pos[2];
  assign out_res.out_color    = res.color;
  assign out_res.play_time    = res.play_time;
  assign out_res.is_playing   = res.is_playing;
  assign out_res.last         = res.last;

endmodule

[hdl/kri_div.sv]
module kri_div import kri_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem,
  output logic             done
);

  logic [DVD_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    sh;
  logic              ge;
  logic [DVS_W:0]    rem_nxt;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    sh      = {rem_r, q_r[DVD_W-1]};
    ge      = sh >= {1'b0, dvs_r};
    rem_nxt = ge ? sh - {1'b0, dvs_r} : sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt[DVS_W-1:0];
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

[hdl/kri_ctrl.sv]
module kri_ctrl import kri_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_TICK: if (sts.loaded && sts.playing) state_nxt = S_TICK_MUL;
            OP_SEEK, OP_STOP: state_nxt = S_WALK_INIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK_MUL:  state_nxt = S_TICK_SUM;
      S_TICK_SUM:  state_nxt = S_TICK_FIN;
      S_TICK_FIN:  state_nxt = sts.tick_div ? S_DIV_M : S_WALK_INIT;
      S_DIV_M:     if (sts.div_done) state_nxt = S_WALK_INIT;
      S_WALK_INIT: state_nxt = sts.loaded ? S_WALK_RD : S_IDLE;
      S_WALK_RD:   state_nxt = S_WALK_CHK;
      S_WALK_CHK:  state_nxt = sts.walk_end ? S_SETUP : S_WALK_RD;
      S_SETUP:     state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.n_zero)   state_nxt = S_IDLE;
        else if (sts.mix) state_nxt = S_DIV_F;
        else              state_nxt = S_AG_RD;
      end
      S_DIV_F:     if (sts.div_done) state_nxt = S_AG_RD;
      S_AG_RD:     state_nxt = S_AG_TAKE;
      S_AG_TAKE:   state_nxt = sts.scan_any ? S_SC_RD : S_OUT;
      S_SC_RD:     state_nxt = S_SC_CHK;
      S_SC_CHK: begin
        if (sts.id_match)      state_nxt = S_LERP_MUL;
        else if (sts.scan_end) state_nxt = S_OUT;
        else                   state_nxt = S_SC_RD;
      end
      S_LERP_MUL:  state_nxt = S_LERP_ADD;
      S_LERP_ADD:  state_nxt = sts.coord_last ? S_OUT : S_LERP_MUL;
      S_OUT: begin
        if (sts.out_free) state_nxt = sts.last_agent ? S_IDLE : S_AG_RD;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        case (in_op)
          OP_LOAD:  cmd.load  = in_valid;
          OP_SEEK:  cmd.seek  = in_valid;
          OP_PLAY:  cmd.play  = in_valid;
          OP_PAUSE: cmd.pause = in_valid;
          OP_STOP:  cmd.stop  = in_valid;
          default: ;
        endcase
      end
      S_TICK_MUL: cmd.tick_mul = 1'b1;
      S_TICK_SUM: cmd.tick_sum = 1'b1;
      S_TICK_FIN: begin
        cmd.div_start = sts.tick_div;
        cmd.tick_fin  = !sts.tick_div;
      end
      S_DIV_M:     cmd.tick_mod = sts.div_done;
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WALK_RD:   cmd.frame_rd = 1'b1;
      S_WALK_CHK:  cmd.walk_chk = 1'b1;
      S_SETUP:     cmd.setup = 1'b1;
      S_DECIDE: begin
        cmd.div_start = sts.mix && !sts.n_zero;
        cmd.div_sel_f = 1'b1;
      end
      S_DIV_F:     cmd.f_take = sts.div_done;
      S_AG_RD:     cmd.ag_rd = 1'b1;
      S_AG_TAKE:   cmd.ag_take = 1'b1;
      S_SC_RD:     cmd.sc_rd = 1'b1;
      S_SC_CHK:    cmd.sc_chk = 1'b1;
      S_LERP_MUL:  cmd.lerp_mul = 1'b1;
      S_LERP_ADD:  cmd.lerp_add = 1'b1;
      S_OUT:       cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/kri_dp.sv]
module kri_dp import kri_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  req_t                  req,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output res_t                  res
);

  // configuration
  logic [SPEED_W-1:0] speed_r;
  logic               looping_r;
  logic [TIME_W-1:0]  duration_r;

  // playback and load state
  logic [TIME_W-1:0]  now_r;
  logic [FRAC_W-1:0]  frac_r;
  logic               playing_r;
  logic [FC_W-1:0]    fc_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [CNT_W-1:0]   cur_cnt_r;
  logic               dropping_r;

  // query registers
  logic [DELTA_W-1:0] delta_r;
  logic [2*SPEED_W-1:0] prod_t_r;
  logic [2*SPEED_W:0] sum_r;
  logic [FRAME_W-1:0] i_r;
  logic               hb_r, ha_r, mix_r;
  logic [FRAME_W-1:0] bidx_r, aidx_r;
  logic [TIME_W-1:0]  bt_r, at_r;
  logic [CNT_W-1:0]   bc_r, ac_r;
  logic [FACT_W-1:0]  f_r;
  logic [SLOT_W-1:0]  k_r, j_r;
  logic [COORD_W-1:0] coord_r;
  logic [ID_W-1:0]    cur_id_r;
  logic [COLOR_W-1:0] cur_color_r;
  logic [NCOORD-1:0][POS_W-1:0] cur_pos_r;
  logic [NCOORD-1:0][POS_W-1:0] late_pos_r;
  logic signed [POS_W+FACT_W+1:0] prod_l_r;
  logic               out_valid_r;
  res_t               res_r;

  // memories
  frame_rec_t frame_mem [MAX_KEYFRAMES];
  agent_rec_t agent_mem [MAX_KEYFRAMES*MAX_AGENTS];
  frame_rec_t frame_q_r;
  agent_rec_t agent_q_r;

  logic [TIME_W-1:0]  dur;
  logic [2*SPEED_W-1:0] d8;
  logic               newkf, full;
  logic [TIME_W-1:0]  lt;
  logic [FRAME_W-1:0] fc_last;
  logic               fw_en, aw_en;
  logic [FRAME_W-1:0] fw_addr;
  frame_rec_t         fw_data;
  logic [AADDR_W-1:0] aw_addr;
  agent_rec_t         aw_data;
  logic [AADDR_W-1:0] ar_addr;
  logic               tick_ge;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_q;
  logic [DVS_W-1:0]   div_rem;
  logic               div_done;
  logic [POS_W-1:0]   lerp_a, lerp_b;
  logic signed [POS_W:0] lerp_diff;

  assign dur     = (duration_r != '0) ? duration_r : last_time_r;
  assign d8      = {dur, FRAC_W'(0)};
  assign newkf   = req.new_keyframe || (fc_r == '0);
  assign full    = fc_r == FC_W'(MAX_KEYFRAMES);
  assign lt      = ((fc_r != '0) && (req.key_time < last_time_r)) ? last_time_r
                                                                 : req.key_time;
  assign fc_last = FRAME_W'(fc_r - FC_W'(1));
  assign tick_ge = sum_r >= {1'b0, d8};

  // load: at most one frame entry and one agent entry written per record
  always_comb begin
    fw_en   = 1'b0;
    aw_en   = 1'b0;
    fw_addr = fc_last;
    fw_data = '{ftime: last_time_r, cnt: cur_cnt_r + CNT_W'(1)};
    aw_addr = {fc_last, cur_cnt_r[SLOT_W-1:0]};
    aw_data = '{id: req.agent_id, pos: req.pos, color: req.color_rgba};
    if (cmd.load) begin
      if (newkf) begin
        if (!full) begin
          fw_en   = 1'b1;
          aw_en   = 1'b1;
          fw_addr = fc_r[FRAME_W-1:0];
          fw_data = '{ftime: lt, cnt: CNT_W'(1)};
          aw_addr = {fc_r[FRAME_W-1:0], SLOT_W'(0)};
        end
      end else if (!dropping_r && (cur_cnt_r < CNT_W'(MAX_AGENTS))) begin
        fw_en = 1'b1;
        aw_en = 1'b1;
      end
    end
  end

  assign ar_addr = cmd.ag_rd ? {bidx_r, k_r} : {aidx_r, j_r};

  always_ff @(posedge clk) begin
    if (fw_en) frame_mem[fw_addr] <= fw_data;
    if (cmd.frame_rd) frame_q_r <= frame_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (aw_en) agent_mem[aw_addr] <= aw_data;
    if (cmd.ag_rd || cmd.sc_rd) agent_q_r <= agent_mem[ar_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_RESET;
      looping_r   <= 1'b0;
      duration_r  <= '0;
      now_r       <= '0;
      frac_r      <= '0;
      playing_r   <= 1'b0;
      fc_r        <= '0;
      last_time_r <= '0;
      cur_cnt_r   <= '0;
      dropping_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPEED:    speed_r    <= cfg_data[SPEED_W-1:0];
          CFG_LOOPING:  looping_r  <= cfg_data[0];
          CFG_DURATION: duration_r <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (newkf) begin
          if (full) begin
            dropping_r <= 1'b1;
          end else begin
            dropping_r  <= 1'b0;
            fc_r        <= fc_r + FC_W'(1);
            last_time_r <= lt;
            cur_cnt_r   <= CNT_W'(1);
          end
        end else if (fw_en) begin
          cur_cnt_r <= cur_cnt_r + CNT_W'(1);
        end
      end
      if ((cmd.play || cmd.pause) && (fc_r != '0)) playing_r <= cmd.play;
      if (cmd.seek) begin
        now_r  <= (req.key_time > dur) ? dur : req.key_time;
        frac_r <= '0;
      end
      if (cmd.stop) begin
        playing_r <= 1'b0;
        now_r     <= '0;
        frac_r    <= '0;
      end
      if (cmd.tick_fin) begin
        if (!tick_ge) begin
          now_r  <= sum_r[2*SPEED_W-1:FRAC_W];
          frac_r <= sum_r[FRAC_W-1:0];
        end else if (looping_r) begin
          now_r  <= '0;   // zero duration wraps to zero
          frac_r <= '0;
        end else begin
          now_r     <= dur;
          frac_r    <= '0;
          playing_r <= 1'b0;
        end
      end
      if (cmd.tick_mod) begin
        now_r  <= div_rem[DVS_W-1:FRAC_W];
        frac_r <= div_rem[FRAC_W-1:0];
      end
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  // query datapath
  assign lerp_a    = cur_pos_r[coord_r];
  assign lerp_b    = late_pos_r[coord_r];
  assign lerp_diff = $signed({lerp_b[POS_W-1], lerp_b}) - $signed({lerp_a[POS_W-1], lerp_a});

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      delta_r <= req.delta_time;
    end
    if (cmd.tick_mul) prod_t_r <= delta_r * speed_r;
    if (cmd.tick_sum) sum_r <= {1'b0, now_r, frac_r} + {1'b0, prod_t_r};
    if (cmd.walk_init) begin
      i_r  <= '0;
      hb_r <= 1'b0;
      ha_r <= 1'b0;
    end
    if (cmd.walk_chk) begin
      i_r <= i_r + FRAME_W'(1);
      if (frame_q_r.ftime <= now_r) begin
        hb_r   <= 1'b1;
        bidx_r <= i_r;
        bt_r   <= frame_q_r.ftime;
        bc_r   <= frame_q_r.cnt;
      end
      if (frame_q_r.ftime >= now_r) begin
        ha_r   <= 1'b1;
        aidx_r <= i_r;
        at_r   <= frame_q_r.ftime;
        ac_r   <= frame_q_r.cnt;
      end
    end
    if (cmd.setup) begin
      k_r   <= '0;
      mix_r <= hb_r && ha_r && (bt_r != at_r);
      if (!hb_r) begin
        bidx_r <= aidx_r;
        bt_r   <= at_r;
        bc_r   <= ac_r;
      end
    end
    if (cmd.f_take) f_r <= div_q[FACT_W-1:0];
    if (cmd.ag_take) begin
      cur_id_r    <= agent_q_r.id;
      cur_pos_r   <= agent_q_r.pos;
      cur_color_r <= agent_q_r.color;
      j_r         <= '0;
      coord_r     <= '0;
    end
    if (cmd.sc_chk) begin
      if (agent_q_r.id == cur_id_r) late_pos_r <= agent_q_r.pos;
      else                          j_r <= j_r + SLOT_W'(1);
    end
    if (cmd.lerp_mul) prod_l_r <= lerp_diff * $signed({1'b0, f_r});
    if (cmd.lerp_add) begin
      // floor(diff * f / 2^16), kept to 24 bits
      cur_pos_r[coord_r] <= lerp_a + prod_l_r[POS_W+FACT_W-1:FACT_W];
      coord_r            <= coord_r + COORD_W'(1);
    end
    if (cmd.emit) begin
      res_r.agent_id   <= cur_id_r;
      res_r.pos        <= cur_pos_r;
      res_r.color      <= cur_color_r;
      res_r.play_time  <= now_r;
      res_r.is_playing <= playing_r;
      res_r.last       <= sts.last_agent;
      k_r              <= k_r + SLOT_W'(1);
    end
  end

  always_comb begin
    if (cmd.div_sel_f) begin
      div_dvd = {now_r - bt_r, FACT_W'(0)};
      div_dvs = DVS_W'(at_r - bt_r);
    end else begin
      div_dvd = DVD_W'(sum_r);
      div_dvs = d8;
    end
  end

  kri_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_q),
    .rem      (div_rem),
    .done     (div_done)
  );

  always_comb begin
    sts.loaded     = fc_r != '0;
    sts.playing    = playing_r;
    sts.tick_div   = tick_ge && looping_r && (dur != '0);
    sts.div_done   = div_done;
    sts.walk_end   = (frame_q_r.ftime >= now_r) || ({1'b0, i_r} == fc_r - FC_W'(1));
    sts.n_zero     = bc_r == '0;
    sts.mix        = mix_r;
    sts.scan_any   = mix_r && (ac_r != '0);
    sts.id_match   = agent_q_r.id == cur_id_r;
    sts.scan_end   = (CNT_W'(j_r) + CNT_W'(1)) == ac_r;
    sts.coord_last = coord_r == COORD_W'(NCOORD - 1);
    sts.out_free   = !out_valid_r || out_ready;
    sts.last_agent = (CNT_W'(k_r) + CNT_W'(1)) == bc_r;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
